FILE: rtl/hbd_pkg.sv
// Shared types and constants of the Huffman bitstream decoder.
package hbd_pkg;

    localparam int IDX_W     = 10;
    localparam int SYM_W     = 8;
    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = $clog2(BYTE_BITS);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_DATA,
        CMD_START
    } cmd_kind_t;

    typedef struct packed {
        logic             is_leaf;
        logic             is_end;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } node_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [IDX_W-1:0]     idx;
        node_t                node;
        logic [BYTE_BITS-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             eom;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

FILE: rtl/hbd_front.sv
// Input front end: accepts stream transactions, classifies them and queues commands.
module hbd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output hbd_pkg::cmd_t cmd
);
    import hbd_pkg::*;

    cmd_t                q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    cmd_t                in_cmd;
    logic                keep;
    logic                push;
    logic                pop;

    always_comb
    begin
        in_cmd.idx          = s_tdata[9:0];
        in_cmd.node.is_leaf = s_tdata[10];
        in_cmd.node.is_end  = s_tdata[11];
        in_cmd.node.sym     = s_tdata[19:12];
        in_cmd.node.lo      = s_tdata[29:20];
        in_cmd.node.hi      = s_tdata[39:30];
        in_cmd.data         = s_tdata[47:40];
        keep                = 1'b1;
        unique case (s_tuser)
            OP_WRITE: in_cmd.kind = CMD_WRITE;
            OP_DATA:  in_cmd.kind = CMD_DATA;
            OP_START: in_cmd.kind = CMD_START;
            default:
            begin
                in_cmd.kind = CMD_WRITE;
                keep        = 1'b0;
            end
        endcase
    end

    assign s_tready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = Q_CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = Q_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/hbd_back.sv
// Execution back end: node table, tree walker and result output register.
module hbd_back #(
    parameter int NODE_COUNT = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  hbd_pkg::cmd_t cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);
    import hbd_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);

    logic [$bits(node_t)-1:0] mem [NODE_COUNT];
    logic [$bits(node_t)-1:0] mem_q;

    state_t               st_reg;
    state_t               st_next;
    logic [IDX_W-1:0]     root_idx_reg;
    logic [IDX_W-1:0]     root_idx_next;
    logic [IDX_W-1:0]     cur_idx_reg;
    logic [IDX_W-1:0]     cur_idx_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 rd_ok_reg;
    logic                 rd_ok_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    result_t              pend_reg;
    result_t              pend_next;
    node_t                root_node_reg;
    node_t                root_node_next;
    node_t                cur_node_reg;
    node_t                cur_node_next;
    logic [BYTE_BITS-1:0] byte_reg;
    logic [BYTE_BITS-1:0] byte_next;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    logic                 out_last_reg;

    node_t                nx;
    logic                 slot_free;
    logic                 stall;
    logic                 last_bit;
    logic                 next_bit;
    logic                 wr_ok;
    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    logic                 push;
    logic                 push_last;

    assign nx        = rd_ok_reg ? node_t'(mem_q) : '0;
    assign slot_free = !out_valid_reg || m_tready;
    assign stall     = nx.is_leaf && pend_valid_reg && !slot_free;
    assign last_bit  = (cnt_reg == CNT_W'(BYTE_BITS - 1));
    assign next_bit  = byte_reg[CNT_W'(cnt_reg + 1'b1)];
    assign wr_ok     = (int'(cmd.idx) < NODE_COUNT);
    assign cmd_ready = (st_reg == ST_IDLE);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == CMD_START)
                    begin
                        st_next = ST_START;
                    end
                    else if (cmd.kind == CMD_DATA && !done_reg)
                    begin
                        st_next = ST_WALK;
                    end
                end
            end
            ST_START:
            begin
                st_next = nx.is_leaf ? ST_FLUSH : ST_IDLE;
            end
            ST_WALK:
            begin
                if (!stall && (last_bit || (nx.is_leaf && nx.is_end)))
                begin
                    st_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        root_idx_next   = root_idx_reg;
        cur_idx_next    = cur_idx_reg;
        done_next       = done_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        root_node_next  = root_node_reg;
        cur_node_next   = cur_node_reg;
        byte_next       = byte_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_idx          = '0;
        push            = 1'b0;
        push_last       = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_WRITE:
                        begin
                            wr_en = wr_ok;
                            if (wr_ok && cmd.idx == root_idx_reg)
                            begin
                                root_node_next = cmd.node;
                            end
                            if (wr_ok && cmd.idx == cur_idx_reg)
                            begin
                                cur_node_next = cmd.node;
                            end
                        end
                        CMD_START:
                        begin
                            rd_en         = 1'b1;
                            rd_idx        = cmd.idx;
                            root_idx_next = cmd.idx;
                            cur_idx_next  = cmd.idx;
                            done_next     = 1'b0;
                        end
                        CMD_DATA:
                        begin
                            if (!done_reg)
                            begin
                                byte_next    = cmd.data;
                                cnt_next     = '0;
                                rd_en        = 1'b1;
                                rd_idx       = cmd.data[0] ? cur_node_reg.hi : cur_node_reg.lo;
                                cur_idx_next = rd_idx;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_START:
            begin
                root_node_next = nx;
                cur_node_next  = nx;
                if (nx.is_leaf)
                begin
                    pend_next       = '{symbol: '0, eom: 1'b1};
                    pend_valid_next = 1'b1;
                    done_next       = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    if (nx.is_leaf)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_next.eom   = nx.is_end;
                        pend_next.symbol = nx.is_end ? '0 : nx.sym;
                        if (nx.is_end)
                        begin
                            done_next = 1'b1;
                        end
                        else if (last_bit)
                        begin
                            cur_idx_next  = root_idx_reg;
                            cur_node_next = root_node_reg;
                        end
                        else
                        begin
                            rd_en        = 1'b1;
                            rd_idx       = next_bit ? root_node_reg.hi : root_node_reg.lo;
                            cur_idx_next = rd_idx;
                            cnt_next     = CNT_W'(cnt_reg + 1'b1);
                        end
                    end
                    else if (last_bit)
                    begin
                        cur_node_next = nx;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_idx       = next_bit ? nx.hi : nx.lo;
                        cur_idx_next = rd_idx;
                        cnt_next     = CNT_W'(cnt_reg + 1'b1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && slot_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign rd_ok_next = rd_en ? (int'(rd_idx) < NODE_COUNT) : rd_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            root_idx_reg   <= '0;
            cur_idx_reg    <= '0;
            done_reg       <= 1'b1;
            cnt_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            root_idx_reg   <= root_idx_next;
            cur_idx_reg    <= cur_idx_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
            rd_ok_reg      <= rd_ok_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        root_node_reg <= root_node_next;
        cur_node_reg  <= cur_node_next;
        byte_reg      <= byte_next;
        if (push)
        begin
            out_res_reg  <= pend_reg;
            out_last_reg <= push_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(cmd.idx)] <= cmd.node;
        end
        if (rd_en)
        begin
            mem_q <= mem[AW'(rd_idx)];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.symbol;
    assign m_tuser  = out_res_reg.eom;
    assign m_tlast  = out_last_reg;

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("A result is still pending while the walker is idle.");

    a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_WALK) |-> !done_reg)
        else $error("The walker is stepping through a finished message.");

    a_leaf_root: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_START && nx.is_leaf) |=>
        (done_reg && pend_valid_reg && st_reg == ST_FLUSH))
        else $error("A leaf root did not produce an end marker.");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && st_reg == ST_FLUSH) |-> push_last)
        else $error("The final result of an item was sent without last.");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!out_valid_reg || m_tready))
        else $error("A result overwrote one that was not yet taken.");

endmodule

FILE: rtl/huffman_bitstream_decoder.sv
// Top level of the Huffman bitstream decoder: command queue front end and tree-walking back end.
//
// Channel  Direction  Signals                    Carries
// s        in         s_tvalid/tready/tdata/tuser  node writes, starts, compressed bytes
// m        out        m_tvalid/tready/tdata/tuser/tlast  decoded symbols and end markers
//
// A node write completes in the idle state; a start passes the start state, then flush for a leaf root.
// A data byte issues the first node-table read in the idle state, follows the remaining bits
// with dependent reads in the walk state, and hands off the final result in the flush state.
// Each further result of a byte waits while the output register is not taken.
// Reset is asynchronous; the node table needs no clearing pass and reads are
// valid only after the entry was written.
// The two-entry command queue accepts input while the back end is busy or stalled.
module huffman_bitstream_decoder #(
    parameter int NODE_COUNT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // node_index[9:0], node_is_leaf[10], node_is_end[11], node_symbol[19:12],
    // left_child[29:20], right_child[39:30], data_byte[47:40]
    input  logic [47:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // symbol[7:0]
    output logic [7:0]  m_tdata,
    // end_of_message[0]
    output logic        m_tuser,
    output logic        m_tlast
);
    import hbd_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    hbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    hbd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: tb/sv/tb_huffman_bitstream_decoder.sv
// Self-checking testbench of the Huffman bitstream decoder with a tree-walking predictor.
module tb_huffman_bitstream_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import hbd_pkg::*;

    localparam int NODES = 1024;
    localparam int ITEM_TARGET = 200;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic        hold;
        logic [1:0]  op;
        logic [47:0] payload;
    } stream_item_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       eom;
        logic       last;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    stream_item_t pending_items[$];
    decoded_t     decoded_expect[$];

    node_t      tree_model[NODES];
    logic [9:0] model_root;
    logic [9:0] model_walk;
    bit         model_idle;

    logic [9:0] written_list[$];

    int items_total;
    int items_accepted;
    int mismatch_count;
    int send_wait;
    int recv_wait;
    int quiet_cycles;
    bit calm_send;
    bit calm_recv;

    huffman_bitstream_decoder #(
        .NODE_COUNT(NODES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 24) == 0)
        begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void predict_decode(input stream_item_t it);
        logic [9:0] idx;
        node_t      cur;
        node_t      nx;
        decoded_t   found[$];
        decoded_t   res;
        idx = it.payload[9:0];
        case (it.op)
            OP_WRITE:
            begin
                tree_model[idx] = '{is_leaf: it.payload[10], is_end: it.payload[11],
                                    sym: it.payload[19:12], lo: it.payload[29:20],
                                    hi: it.payload[39:30]};
            end
            OP_START:
            begin
                model_root = idx;
                model_walk = idx;
                model_idle = 1'b0;
                if (tree_model[idx].is_leaf)
                begin
                    res = '{sym: 8'd0, eom: 1'b1, last: 1'b1};
                    decoded_expect.insert(decoded_expect.size(), res);
                    model_idle = 1'b1;
                end
            end
            OP_DATA:
            begin
                for (int i = 0; i < 8 && !model_idle; i++)
                begin
                    cur = tree_model[model_walk];
                    model_walk = it.payload[40 + i] ? cur.hi : cur.lo;
                    nx = tree_model[model_walk];
                    if (nx.is_leaf)
                    begin
                        if (nx.is_end)
                        begin
                            res = '{sym: 8'd0, eom: 1'b1, last: 1'b0};
                            found.insert(found.size(), res);
                            model_idle = 1'b1;
                        end
                        else
                        begin
                            res = '{sym: nx.sym, eom: 1'b0, last: 1'b0};
                            found.insert(found.size(), res);
                            model_walk = model_root;
                        end
                    end
                end
                for (int k = 0; k < found.size(); k++)
                begin
                    res = found[k];
                    res.last = (k == found.size() - 1);
                    decoded_expect.insert(decoded_expect.size(), res);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic add_item(input logic hold, input logic [1:0] op, input logic [9:0] idx,
                            input logic leaf, input logic is_end, input logic [7:0] sym,
                            input logic [9:0] lo, input logic [9:0] hi,
                            input logic [7:0] data);
        stream_item_t it;
        it.hold = hold;
        it.op = op;
        it.payload = {data, hi, lo, sym, is_end, leaf, idx};
        pending_items.insert(pending_items.size(), it);
        if (op == OP_WRITE)
        begin
            written_list.insert(written_list.size(), idx);
        end
    endtask

    task automatic write_node(input logic [9:0] idx, input logic leaf, input logic is_end,
                              input logic [7:0] sym, input logic [9:0] lo,
                              input logic [9:0] hi);
        add_item(1'b0, OP_WRITE, idx, leaf, is_end, sym, lo, hi, 8'($urandom));
    endtask

    task automatic data_item(input logic [7:0] data);
        add_item(1'b0, OP_DATA, 10'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                 10'($urandom), 10'($urandom), data);
    endtask

    task automatic start_item(input logic [9:0] idx, input logic hold);
        add_item(hold, OP_START, idx, 1'($urandom), 1'($urandom), 8'($urandom),
                 10'($urandom), 10'($urandom), 8'($urandom));
    endtask

    function automatic logic [9:0] any_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // Every written node points only at written nodes, so no walk can reach an unwritten entry.
    task automatic grow_code_tree(input int leaves, input bit with_end,
                                  output logic [9:0] root);
        logic [9:0] subtrees[$];
        logic [9:0] idx;
        logic [9:0] a;
        logic [9:0] b;
        int         pick;
        for (int i = 0; i < leaves; i++)
        begin
            idx = 10'($urandom_range(0, NODES - 1));
            write_node(idx, 1'b1, with_end && i == 0, 8'($urandom), idx, idx);
            subtrees.insert(subtrees.size(), idx);
        end
        while (subtrees.size() > 1)
        begin
            pick = int'($urandom_range(0, subtrees.size() - 1));
            a = subtrees[pick];
            subtrees.delete(pick);
            pick = int'($urandom_range(0, subtrees.size() - 1));
            b = subtrees[pick];
            subtrees.delete(pick);
            idx = 10'($urandom_range(0, NODES - 1));
            write_node(idx, 1'b0, 1'($urandom), 8'($urandom), a, b);
            subtrees.insert(subtrees.size(), idx);
        end
        root = subtrees[0];
    endtask

    task automatic fill_items();
        logic [9:0] root;
        int         messages;
        int         leaves;
        int         nbytes;
        messages = 0;

        add_item(1'b0, OP_NONE, '1, 1'b1, 1'b1, '1, '1, '1, '1);
        data_item(8'hFF);
        write_node(10'd1023, 1'b1, 1'b0, 8'hFF, 10'd1023, 10'd1023);
        write_node(10'd0, 1'b1, 1'b1, 8'h00, 10'd0, 10'd0);
        write_node(10'd512, 1'b0, 1'b1, 8'h5A, 10'd1023, 10'd0);
        start_item(10'd1023, 1'b0);
        start_item(10'd0, 1'b0);
        start_item(10'd512, 1'b0);
        data_item(8'h00);
        data_item(8'hFE);
        data_item(8'h55);
        start_item(10'd512, 1'b0);
        write_node(10'd512, 1'b0, 1'b0, 8'h00, 10'd0, 10'd1023);
        data_item(8'h01);
        write_node(10'd5, 1'b0, 1'b0, 8'h00, 10'd5, 10'd5);
        start_item(10'd5, 1'b0);
        data_item(8'hA5);
        write_node(10'd5, 1'b0, 1'b0, 8'h00, 10'd5, 10'd1023);
        data_item(8'h80);
        write_node(10'd1023, 1'b1, 1'b1, 8'hC3, 10'd1023, 10'd1023);
        data_item(8'h80);
        add_item(1'b0, OP_NONE, '0, 1'b0, 1'b0, '0, '0, '0, '0);

        while (pending_items.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                leaves = ($urandom_range(0, 4) == 0) ? 2 : int'($urandom_range(2, 6));
                grow_code_tree(leaves, $urandom_range(0, 3) != 0, root);
                start_item(root, messages == 0 || messages == 8);
                messages++;
                nbytes = int'($urandom_range(2, 8));
                for (int i = 0; i < nbytes; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        write_node(any_written(), 1'($urandom), 1'($urandom), 8'($urandom),
                                   any_written(), any_written());
                    end
                    data_item(8'($urandom));
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: add_item(1'b0, OP_NONE, 10'($urandom), 1'($urandom), 1'($urandom),
                                8'($urandom), 10'($urandom), 10'($urandom), 8'($urandom));
                    1: start_item(any_written(), 1'b0);
                    2: write_node(10'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                                  any_written(), any_written());
                    default: data_item(8'($urandom));
                endcase
            end
        end
        items_total = pending_items.size();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_decode(pending_items.pop_front());
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0 &&
                         !(pending_items[0].hold && decoded_expect.size() != 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_items[0].payload;
                    s_tuser <= pending_items[0].op;
                    send_wait = draw_wait(calm_send);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_expect.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction sym=%02h eom=%0b last=%0b",
                                              m_tdata, m_tuser, m_tlast));
                end
                else
                begin
                    decoded_t want;
                    want = decoded_expect.pop_front();
                    if (m_tdata !== want.sym)
                        report_mismatch($sformatf("symbol %02h, expected %02h",
                                                  m_tdata, want.sym));
                    if (m_tuser !== want.eom)
                        report_mismatch($sformatf("end_of_message %0b, expected %0b",
                                                  m_tuser, want.eom));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_tlast, want.last));
                end
                recv_wait = draw_wait(calm_recv);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        model_root = '0;
        model_walk = '0;
        model_idle = 1'b1;
        items_accepted = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        calm_send = 1'b0;
        calm_recv = 1'b0;
        fill_items();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (items_accepted < items_total || decoded_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && decoded_expect.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
